// ----- rtl/rtpl_pkg.sv -----
package rtpl_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int ROW_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CSR_W   = 5;
   localparam int CMP_W   = (CSR_W > CNT_W) ? CSR_W : CNT_W;
   localparam int IDX_W   = 4;
   localparam int WCMP_W  = ((ROW_W > IDX_W) ? ROW_W : IDX_W) + 1;
   localparam int ADDR_W  = 32;
   localparam int PLEN_W  = 6;
   localparam int IF_W    = 8;
   localparam int MAX_PLEN = 32;

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [IDX_W-1:0]  row_index;
      logic [ADDR_W-1:0] net_address;
      logic [PLEN_W-1:0] prefix_length;
      logic [ADDR_W-1:0] gateway_address;
      logic [IF_W-1:0]   interface_number;
      logic [ADDR_W-1:0] lookup_address;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  match_row;
      logic [ADDR_W-1:0] next_hop;
      logic [IF_W-1:0]   out_interface;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] network;
      logic [PLEN_W-1:0] prefix;
      logic [ADDR_W-1:0] gateway;
      logic [IF_W-1:0]   intf;
   } row_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
      row_type          row;
   } wr_req_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
   } rd_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // top plen bits set; zero length gives an empty mask, long lengths a full one
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] mask;
      if (plen == '0) begin
         mask = '0;
      end else if (plen >= PLEN_W'(MAX_PLEN)) begin
         mask = '1;
      end else begin
         mask = ~({ADDR_W{1'b1}} >> plen);
      end
      return mask;
   endfunction

endpackage

// ----- rtl/rtpl_table.sv -----
module rtpl_table (
   input  logic                clock,
   input  rtpl_pkg::wr_req_type wr_req,
   input  rtpl_pkg::rd_req_type rd_req,
   output rtpl_pkg::row_type    rd_data
);

   rtpl_pkg::row_type mem [rtpl_pkg::ENTRIES];
   rtpl_pkg::row_type rd_data_ff;

   // store one row
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.row;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rtpl_ctrl.sv -----
module rtpl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rtpl_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rtpl_pkg::rsp_type         rsp_data,
   input  logic [rtpl_pkg::CNT_W-1:0] limit,
   output rtpl_pkg::wr_req_type      wr_req,
   output rtpl_pkg::rd_req_type      rd_req,
   input  rtpl_pkg::row_type         rd_data
);

   rtpl_pkg::state_type state_ff, state_in;
   logic [rtpl_pkg::ROW_W-1:0]  idx_ff, idx_in;
   logic [rtpl_pkg::ROW_W-1:0]  last_ff, last_in;
   logic [rtpl_pkg::ADDR_W-1:0] addr_ff, addr_in;
   rtpl_pkg::rsp_type           res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rtpl_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic                        accept;
   logic                        hit;
   logic                        out_free;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit      = (addr_ff & rtpl_pkg::prefix_mask(rd_data.prefix)) == rd_data.network;

   // write port follows the accepted beat directly
   always_comb begin
      wr_req.en = accept && (req_data.cmd == rtpl_pkg::CMD_WRITE) &&
                  (rtpl_pkg::WCMP_W'(req_data.row_index) <
                   rtpl_pkg::WCMP_W'(rtpl_pkg::ENTRIES));
      wr_req.addr         = rtpl_pkg::ROW_W'(req_data.row_index);
      wr_req.row.network  = req_data.net_address;
      wr_req.row.prefix   = req_data.prefix_length;
      wr_req.row.gateway  = req_data.gateway_address;
      wr_req.row.intf     = req_data.interface_number;
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtpl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // walk the rows one per cycle, first hit wins
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_req.en    = 1'b0;
      rd_req.addr  = idx_ff;
      req_ready    = 1'b0;
      case (state_ff)
         rtpl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept && (req_data.cmd == rtpl_pkg::CMD_LOOKUP)) begin
               addr_in = req_data.lookup_address;
               idx_in  = '0;
               last_in = rtpl_pkg::ROW_W'(limit - rtpl_pkg::CNT_W'(1));
               res_in  = '0;
               if (limit == '0) begin
                  state_in = rtpl_pkg::ST_EMIT;
               end else begin
                  state_in = rtpl_pkg::ST_READ;
               end
            end
         end
         rtpl_pkg::ST_READ: begin
            rd_req.en = 1'b1;
            state_in  = rtpl_pkg::ST_CHECK;
         end
         rtpl_pkg::ST_CHECK: begin
            if (hit) begin
               res_in.found         = 1'b1;
               res_in.match_row     = rtpl_pkg::IDX_W'(idx_ff);
               res_in.next_hop      = rd_data.gateway;
               res_in.out_interface = rd_data.intf;
               state_in             = rtpl_pkg::ST_EMIT;
            end else if (idx_ff == last_ff) begin
               res_in   = '0;
               state_in = rtpl_pkg::ST_EMIT;
            end else begin
               idx_in      = idx_ff + rtpl_pkg::ROW_W'(1);
               rd_req.en   = 1'b1;
               rd_req.addr = idx_ff + rtpl_pkg::ROW_W'(1);
            end
         end
         rtpl_pkg::ST_EMIT: begin
            // hold until the output register frees
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = rtpl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rtpl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/route_table_prefix_lookup_core.sv -----
// channel   direction  payload             accepted when
// req       in         rtpl_pkg::req_type  req_valid & req_ready
// rsp       out        rtpl_pkg::rsp_type  rsp_valid & rsp_ready
// csr       in         5-bit entry_count   csr_valid & csr_ready
//
// A write beat gives no result. A lookup walks the table memory's single read
// port, one row per cycle, over limit = min(entry_count, ENTRIES) rows, and goes
// straight to its result when limit is 0. Reset clears entry_count and the
// control state; the table keeps its contents. A stalled result sits in the
// output register while the next beat is taken; a finished search waits in
// ST_EMIT until the register frees.
module route_table_prefix_lookup_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rtpl_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rtpl_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rtpl_pkg::CSR_W-1:0] csr_data
);

   logic [rtpl_pkg::CSR_W-1:0] count_ff, count_in;
   logic [rtpl_pkg::CNT_W-1:0] limit;
   rtpl_pkg::wr_req_type       wr_req;
   rtpl_pkg::rd_req_type       rd_req;
   rtpl_pkg::row_type          rd_data;

   assign csr_ready = 1'b1;

   // entry count register
   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // clamp the search to the table depth
   always_comb begin
      if (rtpl_pkg::CMP_W'(count_ff) > rtpl_pkg::CMP_W'(rtpl_pkg::ENTRIES)) begin
         limit = rtpl_pkg::CNT_W'(rtpl_pkg::ENTRIES);
      end else begin
         limit = rtpl_pkg::CNT_W'(count_ff);
      end
   end

   rtpl_table u_table (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   rtpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .limit     (limit),
      .wr_req    (wr_req),
      .rd_req    (rd_req),
      .rd_data   (rd_data)
   );

   // a miss carries zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
      (rsp_data.match_row == '0 && rsp_data.next_hop == '0 &&
       rsp_data.out_interface == '0))
      else $error("miss result with non-zero fields");

   // a lookup beat blocks the request side on the next cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == rtpl_pkg::CMD_LOOKUP) |=> !req_ready)
      else $error("request taken during a search");

   // a write beat leaves the block ready again
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == rtpl_pkg::CMD_WRITE) |=> req_ready)
      else $error("write beat did not complete in one cycle");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 25;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PHASES          = 9;
   localparam int BEATS_PER_PHASE = 205;
   localparam int RANDOM_PHASE    = 6;

   // expected route results and a shadow copy of the route rows
   class route_scoreboard;
      logic [rtpl_pkg::ADDR_W-1:0] tbl_net  [rtpl_pkg::ENTRIES];
      logic [rtpl_pkg::PLEN_W-1:0] tbl_plen [rtpl_pkg::ENTRIES];
      logic [rtpl_pkg::ADDR_W-1:0] tbl_gw   [rtpl_pkg::ENTRIES];
      logic [rtpl_pkg::IF_W-1:0]   tbl_if   [rtpl_pkg::ENTRIES];
      logic [rtpl_pkg::CSR_W-1:0]  entry_count;
      rtpl_pkg::rsp_type           expected_routes[$];
      int                          errors;

      function new();
         entry_count = '0;
         errors      = 0;
         foreach (tbl_net[i]) begin
            tbl_net[i]  = '0;
            tbl_plen[i] = '0;
            tbl_gw[i]   = '0;
            tbl_if[i]   = '0;
         end
      endfunction

      // keep the top plen bits; lengths beyond the address width keep all
      function logic [rtpl_pkg::ADDR_W-1:0] route_mask(logic [rtpl_pkg::PLEN_W-1:0] plen);
         logic [63:0] wide;
         if (plen == '0) begin
            return '0;
         end
         if (plen > rtpl_pkg::PLEN_W'(rtpl_pkg::ADDR_W)) begin
            return '1;
         end
         wide = 64'hffff_ffff << (rtpl_pkg::ADDR_W - int'(plen));
         return wide[rtpl_pkg::ADDR_W-1:0];
      endfunction

      // walk the searched rows in order; the first hit wins
      function rtpl_pkg::rsp_type lookup_route(logic [rtpl_pkg::ADDR_W-1:0] addr);
         rtpl_pkg::rsp_type route;
         int                limit;
         route = '0;
         limit = (entry_count > rtpl_pkg::ENTRIES) ? rtpl_pkg::ENTRIES : int'(entry_count);
         for (int i = 0; i < limit; i++) begin
            if ((addr & route_mask(tbl_plen[i])) == tbl_net[i]) begin
               route.found         = 1'b1;
               route.match_row     = rtpl_pkg::IDX_W'(i);
               route.next_hop      = tbl_gw[i];
               route.out_interface = tbl_if[i];
               return route;
            end
         end
         return route;
      endfunction

      function void set_entry_count(logic [rtpl_pkg::CSR_W-1:0] value);
         entry_count = value;
      endfunction

      // store a row, or queue the result that a lookup must give
      function void note_request(rtpl_pkg::req_type item);
         if (item.cmd == rtpl_pkg::CMD_WRITE) begin
            if (int'(item.row_index) < rtpl_pkg::ENTRIES) begin
               tbl_net[item.row_index]  = item.net_address;
               tbl_plen[item.row_index] = item.prefix_length;
               tbl_gw[item.row_index]   = item.gateway_address;
               tbl_if[item.row_index]   = item.interface_number;
            end
         end else begin
            expected_routes.push_back(lookup_route(item.lookup_address));
         end
      endfunction

      function void check_response(rtpl_pkg::rsp_type got);
         rtpl_pkg::rsp_type want;
         if (expected_routes.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_routes.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
         end
         if (got.match_row !== want.match_row) begin
            $error("match_row: expected %0d, actual %0d", want.match_row, got.match_row);
            errors++;
         end
         if (got.next_hop !== want.next_hop) begin
            $error("next_hop: expected %h, actual %h", want.next_hop, got.next_hop);
            errors++;
         end
         if (got.out_interface !== want.out_interface) begin
            $error("out_interface: expected %h, actual %h", want.out_interface,
                   got.out_interface);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   rtpl_pkg::req_type          req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rtpl_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [rtpl_pkg::CSR_W-1:0] csr_data  = '0;

   route_scoreboard    sb = new();
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   int                 searched_rows = 0;
   bit                 long_hold     = 1'b0;
   int                 quiet_cycles  = 0;

   route_table_prefix_lookup_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // result side: random back-pressure, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // check results first, then note new beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
         end
         if (req_valid && req_ready) begin
            sb.note_request(req_data);
         end
         if (csr_valid && csr_ready) begin
            sb.set_entry_count(csr_data);
         end
      end
   end

   // count cycles in which no channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("FAIL route_table_prefix_lookup_core");
      $finish;
   end

   // offer one beat, with random idle cycles ahead of it, and hold until taken
   task automatic send_beat(input rtpl_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid and wait until every result is back and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_routes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [rtpl_pkg::CSR_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      searched_rows = (value > rtpl_pkg::ENTRIES) ? rtpl_pkg::ENTRIES : int'(value);
   endtask

   function automatic rtpl_pkg::req_type row_beat(input int row,
                                                  input logic [rtpl_pkg::ADDR_W-1:0] net,
                                                  input logic [rtpl_pkg::PLEN_W-1:0] plen,
                                                  input logic [rtpl_pkg::ADDR_W-1:0] gw,
                                                  input logic [rtpl_pkg::IF_W-1:0] intf);
      rtpl_pkg::req_type item;
      item                  = '0;
      item.cmd              = rtpl_pkg::CMD_WRITE;
      item.row_index        = rtpl_pkg::IDX_W'(row);
      item.net_address      = net;
      item.prefix_length    = plen;
      item.gateway_address  = gw;
      item.interface_number = intf;
      item.lookup_address   = $urandom;
      return item;
   endfunction

   function automatic rtpl_pkg::req_type lookup_beat(input logic [rtpl_pkg::ADDR_W-1:0] addr);
      rtpl_pkg::req_type item;
      item                = '0;
      item.cmd            = rtpl_pkg::CMD_LOOKUP;
      item.lookup_address = addr;
      return item;
   endfunction

   // mostly well-formed rows and addresses aimed at stored prefixes
   function automatic rtpl_pkg::req_type random_beat(input int limit);
      rtpl_pkg::req_type           item;
      logic [rtpl_pkg::ADDR_W-1:0] mask;
      int                          pick;
      int                          row;
      item.row_index        = rtpl_pkg::IDX_W'($urandom_range(rtpl_pkg::ENTRIES - 1));
      item.net_address      = $urandom;
      item.prefix_length    = rtpl_pkg::PLEN_W'($urandom_range(63));
      item.gateway_address  = $urandom;
      item.interface_number = rtpl_pkg::IF_W'($urandom_range(255));
      item.lookup_address   = $urandom;
      pick = $urandom_range(99);
      if (pick < 30) begin
         item.cmd = rtpl_pkg::CMD_WRITE;
         if (pick < 3) begin
            // default route
            item.prefix_length = '0;
         end else if (pick < 7) begin
            item.prefix_length = rtpl_pkg::PLEN_W'($urandom_range(63, rtpl_pkg::ADDR_W + 1));
         end else begin
            item.prefix_length = rtpl_pkg::PLEN_W'($urandom_range(rtpl_pkg::ADDR_W, 1));
         end
         if ($urandom_range(9) != 0) begin
            item.net_address &= sb.route_mask(item.prefix_length);
         end
      end else begin
         item.cmd = rtpl_pkg::CMD_LOOKUP;
         if (limit > 0 && $urandom_range(99) < 70) begin
            row  = $urandom_range(limit - 1);
            mask = sb.route_mask(sb.tbl_plen[row]);
            item.lookup_address = (sb.tbl_net[row] & mask) | (item.lookup_address & ~mask);
         end
      end
      return item;
   endfunction

   initial begin
      logic [rtpl_pkg::CSR_W-1:0] phase_counts [PHASES];
      logic [rtpl_pkg::CSR_W-1:0] count_setting;
      phase_counts = '{5'd31, 5'd16, 5'd1, 5'd17, 5'd0, 5'd8, 5'd0, 5'd3, 5'd20};
      send_idle_pct = 28;
      recv_idle_pct = 58;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty search after reset: no match
      send_beat(lookup_beat('0));
      send_beat(lookup_beat('1));

      // fill every row: full host route, /16, over-long length, default route
      send_beat(row_beat(0, 32'hffff_ffff, 6'd32, 32'hffff_ffff, 8'hff));
      send_beat(row_beat(1, 32'hc0a8_0000, 6'd16, 32'h0a00_0001, 8'h01));
      send_beat(row_beat(2, 32'h0a00_0000, 6'd63, 32'h0a00_00fe, 8'h02));
      send_beat(row_beat(3, 32'h0000_0000, 6'd0,  32'h1234_5678, 8'h80));
      for (int r = 4; r < rtpl_pkg::ENTRIES; r++) begin
         send_beat(row_beat(r, $urandom & 32'hffff_ff00, 6'd24, $urandom,
                            rtpl_pkg::IF_W'($urandom_range(255))));
      end

      // search beyond the table size
      write_entry_count(5'd31);
      send_beat(lookup_beat(32'hffff_ffff));
      send_beat(lookup_beat(32'hc0a8_abcd));
      send_beat(lookup_beat(32'h0a00_0000));
      send_beat(lookup_beat(32'h0a00_0001));
      send_beat(lookup_beat(32'h0000_0000));
      send_beat(lookup_beat(32'hc0a7_ffff));

      // random phases: receiver-heavy idling, sender-heavy, then none
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         count_setting = (phase == RANDOM_PHASE) ? rtpl_pkg::CSR_W'($urandom_range(31))
                                                 : phase_counts[phase];
         write_entry_count(count_setting);
         if (phase == 1) begin
            long_hold = 1'b1;
         end
         repeat (BEATS_PER_PHASE) send_beat(random_beat(searched_rows));
      end

      drain();
      if (sb.errors == 0) begin
         $display("PASS route_table_prefix_lookup_core");
      end else begin
         $display("FAIL route_table_prefix_lookup_core");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rtpl_pkg.sv
rtl/rtpl_table.sv
rtl/rtpl_ctrl.sv
rtl/route_table_prefix_lookup_core.sv
sim/testbench.sv
